FILE: rtl/tcsa_pkg.sv
// ----------------------------------------------------------------------------
// tcsa_pkg
// Shared types and constants of the two-class service arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcsa_pkg;

   localparam int TIME_BITS_DEFAULT = 16;

   // field widths fixed by the interface
   localparam int ARRIVAL_BITS = 16;
   localparam int SERVICE_BITS = 8;
   localparam int RUN_BITS     = 8;
   localparam int COUNT_BITS   = 16;
   localparam int WAIT_BITS    = 17;
   localparam int SUM_BITS     = 32;
   localparam int LIMIT_BITS   = 16;
   localparam int NOW_BITS     = 16;

   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 136;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [1:0] {
      MODE_ALTERNATE     = 2'd0,
      MODE_PRIORITY_1ST  = 2'd1,
      MODE_REGULAR_1ST   = 2'd2,
      MODE_RATIO         = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      GRANT_NONE     = 2'd0,
      GRANT_REGULAR  = 2'd1,
      GRANT_PRIORITY = 2'd2,
      GRANT_UNUSED   = 2'd3
   } grant_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_POLICY_MODE  = 2'd0,
      CSR_REGULAR_RUN  = 2'd1,
      CSR_PRIORITY_RUN = 2'd2,
      CSR_TIME_LIMIT   = 2'd3
   } csr_index_type;

   localparam logic [1:0]            POLICY_MODE_RESET  = 2'd0;
   localparam logic [RUN_BITS-1:0]   REGULAR_RUN_RESET  = 8'd3;
   localparam logic [RUN_BITS-1:0]   PRIORITY_RUN_RESET = 8'd1;
   localparam logic [LIMIT_BITS-1:0] TIME_LIMIT_RESET   = 16'd480;

endpackage

`default_nettype wire

FILE: rtl/two_class_service_arbiter.sv
// ----------------------------------------------------------------------------
// two_class_service_arbiter
// Single-server arbiter between a regular and a priority queue.
// ----------------------------------------------------------------------------
// Each request beat is one arbitration decision and yields exactly one
// response beat. A beat is captured in an input register, decided by one
// pass of logic against the time, run and statistics registers, and lands
// in the response register; a new beat is taken every cycle while the
// response side keeps up, so the rate is one decision per clock. The
// arbitration state moves on when a decision leaves the input register,
// so back-to-back beats see each other's updates.
// Configuration is written through the csr channel, which is always ready.
`default_nettype none

module two_class_service_arbiter
   import tcsa_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   // request: regular_pending, regular_arrival[16], regular_service[8],
   //          priority_pending, priority_arrival[16], priority_service[8], zero pad
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // response: grant[2], wait_time[17], time_now[16], done_res,
   //           regular_count[16], priority_count[16], regular_wait_sum[32],
   //           priority_wait_sum[32], zero pad
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata
);

   localparam int CW = (TIME_BITS > ARRIVAL_BITS) ? TIME_BITS : ARRIVAL_BITS;
   localparam int WB = CW + 1;
   localparam int SW = ((WB > SUM_BITS) ? WB : SUM_BITS) + 1;

   localparam logic signed [WB-1:0] WAIT_MAX = WB'(18'sd65535);
   localparam logic signed [WB-1:0] WAIT_MIN = WB'(-18'sd65535);
   localparam logic signed [SW-1:0] SUM_MAX  = SW'(33'sh0_7fff_ffff);
   localparam logic signed [SW-1:0] SUM_MIN  = SW'(-33'sh0_8000_0000);

   // configuration registers
   mode_type               mode_ff;
   logic [RUN_BITS-1:0]    reg_len_ff;
   logic [RUN_BITS-1:0]    pri_len_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= mode_type'(POLICY_MODE_RESET);
         reg_len_ff <= REGULAR_RUN_RESET;
         pri_len_ff <= PRIORITY_RUN_RESET;
         limit_ff   <= TIME_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLICY_MODE:  mode_ff    <= mode_type'(csr_data[1:0]);
            CSR_REGULAR_RUN:  reg_len_ff <= csr_data[RUN_BITS-1:0];
            CSR_PRIORITY_RUN: pri_len_ff <= csr_data[RUN_BITS-1:0];
            CSR_TIME_LIMIT:   limit_ff   <= csr_data;
            default:          ;
         endcase
      end
   end

   // input register
   logic                    in_valid_ff;
   logic                    rp_ff, pp_ff;
   logic [ARRIVAL_BITS-1:0] ra_ff, pa_ff;
   logic [SERVICE_BITS-1:0] rs_ff, ps_ff;
   logic                    advance;

   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         rp_ff <= req_tdata[0];
         ra_ff <= req_tdata[16:1];
         rs_ff <= req_tdata[24:17];
         pp_ff <= req_tdata[25];
         pa_ff <= req_tdata[41:26];
         ps_ff <= req_tdata[49:42];
      end
   end

   // arbitration state
   logic [TIME_BITS-1:0]  time_ff,    time_in;
   logic                  prefer_ff,  prefer_in;
   logic                  phase_ff,   phase_in;   // ratio phase, high in priority run
   logic [RUN_BITS-1:0]   rcnt_ff,    rcnt_in;
   logic [RUN_BITS-1:0]   pcnt_ff,    pcnt_in;
   logic [COUNT_BITS-1:0] rserved_ff, rserved_in;
   logic [COUNT_BITS-1:0] pserved_ff, pserved_in;
   logic signed [SUM_BITS-1:0] rsum_ff, rsum_in;
   logic signed [SUM_BITS-1:0] psum_ff, psum_in;

   grant_type              grant;
   logic                   done;
   logic signed [WB-1:0]   wait_full;
   logic signed [WAIT_BITS-1:0] wait_out;

   always_comb begin
      logic [CW-1:0]           time_ext;
      logic [CW-1:0]           arrival_ext;
      logic                    idle_tick;
      logic [SERVICE_BITS-1:0] step;
      logic [TIME_BITS:0]      time_sum;
      logic [RUN_BITS-1:0]     cnt_next;
      logic signed [SW-1:0]    sum_old;
      logic signed [SW-1:0]    sum_new;
      logic signed [SUM_BITS-1:0] sum_sat;

      time_ext  = CW'(time_ff);
      grant     = GRANT_NONE;
      done      = 1'b0;
      idle_tick = 1'b0;
      cnt_next  = '0;
      prefer_in = prefer_ff;
      phase_in  = phase_ff;
      rcnt_in   = rcnt_ff;
      pcnt_in   = pcnt_ff;

      if ((time_ext >= CW'(limit_ff)) || (!rp_ff && !pp_ff)) begin
         done = 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_ALTERNATE: begin
               if (prefer_ff) grant = pp_ff ? GRANT_PRIORITY : GRANT_REGULAR;
               else           grant = rp_ff ? GRANT_REGULAR  : GRANT_PRIORITY;
               prefer_in = !prefer_ff;
            end
            MODE_PRIORITY_1ST: grant = pp_ff ? GRANT_PRIORITY : GRANT_REGULAR;
            MODE_REGULAR_1ST:  grant = rp_ff ? GRANT_REGULAR  : GRANT_PRIORITY;
            MODE_RATIO: begin
               if (!phase_ff) begin
                  if (rp_ff) begin
                     grant    = GRANT_REGULAR;
                     cnt_next = rcnt_ff + 1'b1;
                     if (cnt_next >= reg_len_ff) begin
                        rcnt_in  = '0;
                        phase_in = 1'b1;
                     end else begin
                        rcnt_in = cnt_next;
                     end
                  end else begin
                     // empty regular run hands over to priority in the same decision
                     rcnt_in  = '0;
                     phase_in = 1'b1;
                  end
               end
               if (grant == GRANT_NONE && phase_in) begin
                  if (pp_ff) begin
                     grant    = GRANT_PRIORITY;
                     cnt_next = pcnt_ff + 1'b1;
                     if (cnt_next >= pri_len_ff) begin
                        pcnt_in  = '0;
                        phase_in = 1'b0;
                     end else begin
                        pcnt_in = cnt_next;
                     end
                  end else begin
                     pcnt_in   = '0;
                     phase_in  = 1'b0;
                     idle_tick = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      // wait and time advance
      arrival_ext = (grant == GRANT_PRIORITY) ? CW'(pa_ff) : CW'(ra_ff);
      wait_full   = $signed({1'b0, time_ext}) - $signed({1'b0, arrival_ext});
      unique case (grant)
         GRANT_REGULAR:  step = rs_ff;
         GRANT_PRIORITY: step = ps_ff;
         default:        step = SERVICE_BITS'(idle_tick);
      endcase
      time_sum = {1'b0, time_ff} + (TIME_BITS+1)'(step);
      time_in  = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];

      if (grant == GRANT_NONE) begin
         wait_out = '0;
      end else if (wait_full > WAIT_MAX) begin
         wait_out = WAIT_BITS'(WAIT_MAX);
      end else if (wait_full < WAIT_MIN) begin
         wait_out = WAIT_BITS'(WAIT_MIN);
      end else begin
         wait_out = WAIT_BITS'(wait_full);
      end

      // saturating wait sum for the granted class
      sum_old = (grant == GRANT_PRIORITY) ? SW'(psum_ff) : SW'(rsum_ff);
      sum_new = sum_old + SW'(wait_full);
      if (sum_new > SUM_MAX)      sum_sat = SUM_BITS'(SUM_MAX);
      else if (sum_new < SUM_MIN) sum_sat = SUM_BITS'(SUM_MIN);
      else                        sum_sat = SUM_BITS'(sum_new);

      rserved_in = rserved_ff;
      pserved_in = pserved_ff;
      rsum_in    = rsum_ff;
      psum_in    = psum_ff;
      if (grant == GRANT_REGULAR) begin
         if (rserved_ff != '1) rserved_in = rserved_ff + 1'b1;
         rsum_in = sum_sat;
      end else if (grant == GRANT_PRIORITY) begin
         if (pserved_ff != '1) pserved_in = pserved_ff + 1'b1;
         psum_in = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         prefer_ff  <= 1'b1;
         phase_ff   <= 1'b0;
         rcnt_ff    <= '0;
         pcnt_ff    <= '0;
         rserved_ff <= '0;
         pserved_ff <= '0;
         rsum_ff    <= '0;
         psum_ff    <= '0;
      end else if (advance) begin
         time_ff    <= time_in;
         prefer_ff  <= prefer_in;
         phase_ff   <= phase_in;
         rcnt_ff    <= rcnt_in;
         pcnt_ff    <= pcnt_in;
         rserved_ff <= rserved_in;
         pserved_ff <= pserved_in;
         rsum_ff    <= rsum_in;
         psum_ff    <= psum_in;
      end
   end

   // response register
   logic [CW-1:0] now_ext;
   assign now_ext = CW'(time_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (advance) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata <= {4'd0, psum_in, rsum_in, pserved_in, rserved_in, done,
                       now_ext[NOW_BITS-1:0], wait_out, grant};
      end
   end

endmodule

`default_nettype wire
